// ===== sv/cbs_pkg.sv =====
package cbs_pkg;

   // Field widths
   localparam int VOLT_W   = 16;
   localparam int MASK_W   = 12;
   localparam int QCNT_W   = 4;
   localparam int CCOUNT_W = 4;
   localparam int MAXDIS_W = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_COUNT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BALANCE_VOLTAGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_VOLTAGE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALWAYS_BALANCE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISCHARGING = 3'd4;

   // Register reset values
   localparam logic [CCOUNT_W-1:0] RST_CELL_COUNT      = 4'd12;
   localparam logic [VOLT_W-1:0]   RST_BALANCE_VOLTAGE = 16'd4150;
   localparam logic [VOLT_W-1:0]   RST_DIFF_VOLTAGE    = 16'd10;
   localparam logic                RST_ALWAYS_BALANCE  = 1'b0;
   localparam logic [MAXDIS_W-1:0] RST_MAX_DISCHARGING = 4'd5;

   // Lowest-cell reference starts here and never exceeds it
   localparam logic [VOLT_W-1:0] LOWEST_CAP = 16'd60000;

   // Reported count saturates here
   localparam logic [QCNT_W-1:0] QCNT_MAX = 4'd15;

   localparam int CELL_SLOTS_DEF = 12;

   // Datapath operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP  = 3'd0;
   localparam logic [OP_W-1:0] OP_INIT = 3'd1;
   localparam logic [OP_W-1:0] OP_MIN  = 3'd2;
   localparam logic [OP_W-1:0] OP_QUAL = 3'd3;
   localparam logic [OP_W-1:0] OP_RANK = 3'd4;

   typedef struct packed {
      logic [CCOUNT_W-1:0] cell_count;
      logic [VOLT_W-1:0]   balance_voltage;
      logic [VOLT_W-1:0]   diff_voltage;
      logic                always_balance;
      logic [MAXDIS_W-1:0] max_discharging;
   } cfg_type;

   // op and rank_end are registered and act in the next cycle, with the memory read data;
   // publish acts in the cycle it is issued
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            rank_end;
      logic            publish;
   } cmd_type;

endpackage

// ===== sv/cbs_csr.sv =====
module cbs_csr
   import cbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CELL_COUNT:      cfg_in.cell_count      = csr_wdata[CCOUNT_W-1:0];
            CSR_BALANCE_VOLTAGE: cfg_in.balance_voltage = csr_wdata[VOLT_W-1:0];
            CSR_DIFF_VOLTAGE:    cfg_in.diff_voltage    = csr_wdata[VOLT_W-1:0];
            CSR_ALWAYS_BALANCE:  cfg_in.always_balance  = csr_wdata[0];
            CSR_MAX_DISCHARGING: cfg_in.max_discharging = csr_wdata[MAXDIS_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_count      <= RST_CELL_COUNT;
         cfg_ff.balance_voltage <= RST_BALANCE_VOLTAGE;
         cfg_ff.diff_voltage    <= RST_DIFF_VOLTAGE;
         cfg_ff.always_balance  <= RST_ALWAYS_BALANCE;
         cfg_ff.max_discharging <= RST_MAX_DISCHARGING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/cbs_dp.sv =====
module cbs_dp
   import cbs_pkg::*;
#(
   parameter int CELL_SLOTS = CELL_SLOTS_DEF,
   parameter int IDX_W      = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1,
   parameter int CNT_W      = $clog2(CELL_SLOTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  cmd_type           cmd,
   input  logic [IDX_W-1:0]  addr_i,
   input  logic [IDX_W-1:0]  addr_j,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [VOLT_W-1:0] wr_data,
   output logic [MASK_W-1:0] rsp_discharge_mask,
   output logic [QCNT_W-1:0] rsp_qualifying_count,
   output logic              rsp_request_5v
);

   // Cell voltage memory: one write port, two registered read ports
   logic [VOLT_W-1:0] mem_ff [CELL_SLOTS];
   logic [VOLT_W-1:0] rd_a_ff, rd_b_ff;

   // Command delayed to line up with the read data
   logic [OP_W-1:0]  op_ff;
   logic             rank_end_ff;
   logic [IDX_W-1:0] ci_ff, cj_ff;

   // Working state
   logic [VOLT_W-1:0]     lowest_ff, lowest_in;
   logic [CELL_SLOTS-1:0] qual_ff, qual_in;
   logic [CELL_SLOTS-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      ahead_ff, ahead_in;

   // Result registers
   logic [MASK_W-1:0] out_mask_ff, out_mask_in;
   logic [QCNT_W-1:0] out_count_ff, out_count_in;

   logic              qual_now;
   logic              rank_inc;
   logic [CNT_W-1:0]  ahead_next;
   logic [VOLT_W:0]   qual_floor;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[addr_i];
      rd_b_ff <= mem_ff[addr_j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_NOP;
      end else begin
         op_ff <= cmd.op;
      end
      rank_end_ff <= cmd.rank_end;
      ci_ff       <= addr_i;
      cj_ff       <= addr_j;
   end

   // Qualify against balance voltage and lowest cell plus allowed difference
   assign qual_floor = {1'b0, lowest_ff} + {1'b0, cfg.diff_voltage};
   assign qual_now   = (rd_a_ff >= cfg.balance_voltage) &&
                       ({1'b0, rd_a_ff} > qual_floor);

   // Cell j ranks ahead of cell i when higher, or equal with lower index
   assign rank_inc = qual_ff[ci_ff] && qual_ff[cj_ff] && (ci_ff != cj_ff) &&
                     ((rd_b_ff > rd_a_ff) || ((rd_b_ff == rd_a_ff) && (cj_ff < ci_ff)));
   assign ahead_next = ahead_ff + CNT_W'(rank_inc);

   always_comb begin
      lowest_in = lowest_ff;
      qual_in   = qual_ff;
      mask_in   = mask_ff;
      count_in  = count_ff;
      ahead_in  = ahead_ff;
      unique case (op_ff)
         OP_NOP: begin
         end
         OP_INIT: begin
            lowest_in = LOWEST_CAP;
            qual_in   = '0;
            mask_in   = '0;
            count_in  = '0;
            ahead_in  = '0;
         end
         OP_MIN: begin
            if (rd_a_ff < lowest_ff) begin
               lowest_in = rd_a_ff;
            end
         end
         OP_QUAL: begin
            qual_in[ci_ff] = qual_now;
            count_in       = count_ff + CNT_W'(qual_now);
         end
         OP_RANK: begin
            ahead_in = ahead_next;
            if (rank_end_ff) begin
               ahead_in = '0;
               if (qual_ff[ci_ff] && (32'(ahead_next) < 32'(cfg.max_discharging))) begin
                  mask_in[ci_ff] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lowest_ff <= lowest_in;
      qual_ff   <= qual_in;
      mask_ff   <= mask_in;
      count_ff  <= count_in;
      ahead_ff  <= ahead_in;
   end

   // Map the working mask onto the fixed-width result; extra cells drop out
   logic [MASK_W-1:0] mask_wide;
   for (genvar k = 0; k < MASK_W; k++) begin : g_mask
      if (k < CELL_SLOTS) begin : g_on
         assign mask_wide[k] = mask_ff[k];
      end else begin : g_off
         assign mask_wide[k] = 1'b0;
      end
   end

   // Load result registers on publish
   always_comb begin
      out_mask_in  = out_mask_ff;
      out_count_in = out_count_ff;
      if (cmd.publish) begin
         out_mask_in  = mask_wide;
         out_count_in = (32'(count_ff) > 32'(QCNT_MAX)) ? QCNT_MAX : QCNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      out_mask_ff  <= out_mask_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_discharge_mask   = out_mask_ff;
   assign rsp_qualifying_count = out_count_ff;
   assign rsp_request_5v       = (out_count_ff != '0);

endmodule

// ===== sv/cbs_ctrl.sv =====
module cbs_ctrl
   import cbs_pkg::*;
#(
   parameter int CELL_SLOTS = CELL_SLOTS_DEF,
   parameter int IDX_W      = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1,
   parameter int CNT_W      = $clog2(CELL_SLOTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_charging_active,
   input  logic             req_last_cell,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] addr_i,
   output logic [IDX_W-1:0] addr_j,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_MIN   = 3'd2;
   localparam logic [2:0] S_QUAL  = 3'd3;
   localparam logic [2:0] S_RANK  = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_PUB   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] ptr_i_ff, ptr_i_in;
   logic [IDX_W-1:0] ptr_j_ff, ptr_j_in;
   logic [CNT_W-1:0] load_idx_ff, load_idx_in;
   logic             charging_ff, charging_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             req_take;
   logic [CNT_W-1:0] n_cells;
   logic             i_last, j_last;

   // Clamp cell count to the store depth
   assign n_cells = (32'(cfg.cell_count) > CELL_SLOTS) ? CNT_W'(CELL_SLOTS)
                                                       : CNT_W'(cfg.cell_count);
   assign i_last  = (CNT_W'(ptr_i_ff) == n_cells - CNT_W'(1));
   assign j_last  = (CNT_W'(ptr_j_ff) == n_cells - CNT_W'(1));

   assign req_stall = (state_ff != S_LOAD);
   assign req_take  = req_valid && !req_stall;

   // Store the voltage while the store has room
   assign wr_en   = req_take && (32'(load_idx_ff) < CELL_SLOTS);
   assign wr_addr = load_idx_ff[IDX_W-1:0];

   assign addr_i = ptr_i_ff;
   assign addr_j = ptr_j_ff;

   always_comb begin
      state_in     = state_ff;
      ptr_i_in     = ptr_i_ff;
      ptr_j_in     = ptr_j_ff;
      load_idx_in  = load_idx_ff;
      charging_in  = charging_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.op       = OP_NOP;
      cmd.rank_end = 1'b0;
      cmd.publish  = 1'b0;

      // Drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_take) begin
               if (req_last_cell) begin
                  load_idx_in = '0;
                  charging_in = req_charging_active;
                  state_in    = S_INIT;
               end else if (wr_en) begin
                  load_idx_in = load_idx_ff + CNT_W'(1);
               end
            end
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            ptr_i_in = '0;
            ptr_j_in = '0;
            if ((charging_ff || cfg.always_balance) && (n_cells != '0)) begin
               state_in = S_MIN;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_MIN: begin
            cmd.op = OP_MIN;
            if (i_last) begin
               ptr_i_in = '0;
               state_in = S_QUAL;
            end else begin
               ptr_i_in = ptr_i_ff + IDX_W'(1);
            end
         end
         S_QUAL: begin
            cmd.op = OP_QUAL;
            if (i_last) begin
               ptr_i_in = '0;
               state_in = S_RANK;
            end else begin
               ptr_i_in = ptr_i_ff + IDX_W'(1);
            end
         end
         S_RANK: begin
            cmd.op       = OP_RANK;
            cmd.rank_end = j_last;
            if (j_last) begin
               ptr_j_in = '0;
               if (i_last) begin
                  ptr_i_in = '0;
                  state_in = S_DRAIN;
               end else begin
                  ptr_i_in = ptr_i_ff + IDX_W'(1);
               end
            end else begin
               ptr_j_in = ptr_j_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            // Let the last datapath step settle
            state_in = S_PUB;
         end
         S_PUB: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         ptr_i_ff     <= '0;
         ptr_j_ff     <= '0;
         load_idx_ff  <= '0;
         charging_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_i_ff     <= ptr_i_in;
         ptr_j_ff     <= ptr_j_in;
         load_idx_ff  <= load_idx_in;
         charging_ff  <= charging_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/cell_balance_selector_core.sv =====
// Passive cell balancing selector.
// Request channel (req_*): one cell voltage per item, in cell order; the item
// with req_last_cell set ends the scan and carries the charging flag.
// Voltages load at one item per cycle. After the last item the request side
// stalls while the pack is evaluated: lowest-cell search, qualify pass and a
// pairwise ranking pass over the clamped cell count through the two-read-port
// cell memory; the passes are skipped when balancing is off or the cell count
// is zero. Loading of the next scan resumes as soon as the result is in the
// output register.
// Response channel (rsp_*): one item per scan holding the discharge mask, the
// qualifying cell count and the 5V request. A stalled result holds; a later
// result waits in the evaluator until the output register frees up.
// Configuration (csr_*): write-only registers, to be written by the user only
// while the block is idle; the block itself does not enforce this.
// Reset is synchronous: registers return to their defaults, the load index
// returns to cell zero and no result is pending.
module cell_balance_selector_core
   import cbs_pkg::*;
#(
   parameter int CELL_SLOTS = CELL_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VOLT_W-1:0]     req_cell_voltage,
   input  logic                  req_charging_active,
   input  logic                  req_last_cell,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MASK_W-1:0]     rsp_discharge_mask,
   output logic [QCNT_W-1:0]     rsp_qualifying_count,
   output logic                  rsp_request_5v
);

   localparam int IDX_W = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
   localparam int CNT_W = $clog2(CELL_SLOTS + 1);

   cfg_type          cfg;
   cmd_type          cmd;
   logic [IDX_W-1:0] addr_i, addr_j, wr_addr;
   logic             wr_en;

   cbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cbs_ctrl #(
      .CELL_SLOTS (CELL_SLOTS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_charging_active (req_charging_active),
      .req_last_cell       (req_last_cell),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .cmd                 (cmd),
      .addr_i              (addr_i),
      .addr_j              (addr_j),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr)
   );

   cbs_dp #(
      .CELL_SLOTS (CELL_SLOTS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .addr_i               (addr_i),
      .addr_j               (addr_j),
      .wr_en                (wr_en),
      .wr_addr              (wr_addr),
      .wr_data              (req_cell_voltage),
      .rsp_discharge_mask   (rsp_discharge_mask),
      .rsp_qualifying_count (rsp_qualifying_count),
      .rsp_request_5v       (rsp_request_5v)
   );

endmodule

// ===== tb/tb_cell_balance_selector_core.sv =====
`timescale 1ns / 1ps

module tb_cell_balance_selector_core;
   import cbs_pkg::*;

   localparam int          ITEMS_PER_PHASE = 150;
   localparam int          NUM_PHASES      = 12;
   localparam int          SETTLE_CYCLES   = 8;
   localparam int          TAIL_CYCLES     = 200;
   localparam int          HOLD_CYCLES     = 600;
   localparam int          REPORT_LIMIT    = 10;
   localparam int unsigned CYCLE_LIMIT     = 2000000;

   // Index with no register behind it; writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   // Mixed scan: full-scale cell, a tie at 4200, cells right at the threshold
   localparam logic [VOLT_W-1:0] TIE_SCAN [CELL_SLOTS_DEF] = '{
      16'd4200, 16'd4200, 16'd4160, 16'd65535, 16'd4150, 16'd4149,
      16'd4300, 16'd4300, 16'd4300, 16'd4140, 16'd4155, 16'd4170
   };

   typedef struct {
      logic [MASK_W-1:0] mask;
      logic [QCNT_W-1:0] count;
      logic              rail;
   } discharge_result_type;

   // Tracks the pack state seen by the block and the results it still owes
   class discharge_tracker;
      cfg_type              regs;
      logic [VOLT_W-1:0]    cells [CELL_SLOTS_DEF];
      int                   load_idx;
      discharge_result_type awaited [$];
      int                   errors;

      function new();
         regs.cell_count      = RST_CELL_COUNT;
         regs.balance_voltage = RST_BALANCE_VOLTAGE;
         regs.diff_voltage    = RST_DIFF_VOLTAGE;
         regs.always_balance  = RST_ALWAYS_BALANCE;
         regs.max_discharging = RST_MAX_DISCHARGING;
         foreach (cells[i]) cells[i] = '0;
         load_idx = 0;
         errors   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CELL_COUNT:      regs.cell_count      = data[CCOUNT_W-1:0];
            CSR_BALANCE_VOLTAGE: regs.balance_voltage = data[VOLT_W-1:0];
            CSR_DIFF_VOLTAGE:    regs.diff_voltage    = data[VOLT_W-1:0];
            CSR_ALWAYS_BALANCE:  regs.always_balance  = data[0];
            CSR_MAX_DISCHARGING: regs.max_discharging = data[MAXDIS_W-1:0];
            default: ;
         endcase
      endfunction

      function discharge_result_type predict_discharge(logic charging);
         discharge_result_type      res;
         int unsigned               n, lowest, cnt, ahead;
         logic [CELL_SLOTS_DEF-1:0] qual;
         res.mask  = '0;
         res.count = '0;
         res.rail  = 1'b0;
         n = (regs.cell_count > CELL_SLOTS_DEF) ? CELL_SLOTS_DEF : regs.cell_count;
         if (n == 0 || (!charging && !regs.always_balance)) return res;
         // lowest reference, capped
         lowest = LOWEST_CAP;
         for (int i = 0; i < n; i++)
            if (cells[i] < lowest) lowest = cells[i];
         // qualify against threshold and spread
         cnt  = 0;
         qual = '0;
         for (int i = 0; i < n; i++) begin
            qual[i] = (cells[i] >= regs.balance_voltage) &&
                      (cells[i] > lowest + regs.diff_voltage);
            if (qual[i]) cnt++;
         end
         // rank: highest first, ties to the lower index
         for (int i = 0; i < n; i++) begin
            if (!qual[i]) continue;
            ahead = 0;
            for (int j = 0; j < n; j++)
               if (qual[j] && j != i &&
                   (cells[j] > cells[i] || (cells[j] == cells[i] && j < i)))
                  ahead++;
            if (ahead < regs.max_discharging) res.mask[i] = 1'b1;
         end
         res.count = (cnt > QCNT_MAX) ? QCNT_MAX : cnt[QCNT_W-1:0];
         res.rail  = (cnt != 0);
         return res;
      endfunction

      function void note_cell(logic [VOLT_W-1:0] volts, logic charging, logic ends_scan);
         // drop voltages past the last cell slot
         if (load_idx < CELL_SLOTS_DEF) begin
            cells[load_idx] = volts;
            load_idx++;
         end
         if (ends_scan) begin
            load_idx = 0;
            awaited.push_back(predict_discharge(charging));
         end
      endfunction

      function void check_result(logic [MASK_W-1:0] mask, logic [QCNT_W-1:0] count,
                                 logic rail);
         discharge_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected result: mask %03h count %0d 5v %0b", mask, count, rail);
            return;
         end
         want = awaited.pop_front();
         if (want.mask !== mask || want.count !== count || want.rail !== rail) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display({"result mismatch: mask exp %03h got %03h, ",
                         "count exp %0d got %0d, 5v exp %0b got %0b"},
                        want.mask, mask, want.count, count, want.rail, rail);
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                  clock                = 1'b0;
   logic                  reset                = 1'b1;
   logic                  csr_write            = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index            = '0;
   logic [CSR_DATA_W-1:0] csr_wdata            = '0;
   logic                  req_valid            = 1'b0;
   logic                  req_stall;
   logic [VOLT_W-1:0]     req_cell_voltage     = '0;
   logic                  req_charging_active  = 1'b0;
   logic                  req_last_cell        = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall            = 1'b0;
   logic [MASK_W-1:0]     rsp_discharge_mask;
   logic [QCNT_W-1:0]     rsp_qualifying_count;
   logic                  rsp_request_5v;

   discharge_tracker tracker = new();
   int               idle_pct     = 20;
   int               phase_center = 4100;
   bit               hold_request = 1'b0;
   int               hold_left    = 0;
   int unsigned      cycle_count  = 0;

   cell_balance_selector_core uut (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cell_voltage     (req_cell_voltage),
      .req_charging_active  (req_charging_active),
      .req_last_cell        (req_last_cell),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_discharge_mask   (rsp_discharge_mask),
      .rsp_qualifying_count (rsp_qualifying_count),
      .rsp_request_5v       (rsp_request_5v)
   );

   always #6 clock = ~clock;

   // Watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Result side: check accepted items, stall at random or for a long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_result(rsp_discharge_mask, rsp_qualifying_count, rsp_request_5v);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   // Offer one item, idling first at random; valid stays high on return
   task automatic send_item(input logic [VOLT_W-1:0] volts, input logic charging,
                            input logic ends_scan);
      while ($urandom_range(99) < idle_pct) begin
         req_valid           <= 1'b0;
         req_cell_voltage    <= 16'($urandom);
         req_charging_active <= 1'($urandom_range(1));
         req_last_cell       <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_cell_voltage    <= volts;
      req_charging_active <= charging;
      req_last_cell       <= ends_scan;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_cell(volts, charging, ends_scan);
   endtask

   // Drop valid and hold until every owed result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all registers plus the unused index; narrow ones get noisy upper bits
   task automatic apply_settings(input cfg_type s);
      logic [CSR_IDX_W-1:0]  idx [6];
      logic [CSR_DATA_W-1:0] val [6];
      logic [CSR_DATA_W-1:0] noise;
      noise  = 16'($urandom);
      idx[0] = CSR_UNUSED;          val[0] = ~noise;
      idx[1] = CSR_CELL_COUNT;      val[1] = {noise[15:4], s.cell_count};
      idx[2] = CSR_BALANCE_VOLTAGE; val[2] = s.balance_voltage;
      idx[3] = CSR_DIFF_VOLTAGE;    val[3] = s.diff_voltage;
      idx[4] = CSR_ALWAYS_BALANCE;  val[4] = {noise[15:1], s.always_balance};
      idx[5] = CSR_MAX_DISCHARGING; val[5] = {noise[11:0], s.max_discharging};
      for (int k = 0; k < 6; k++) begin
         csr_write <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         tracker.write_reg(idx[k], val[k]);
      end
      csr_write <= 1'b0;
   endtask

   // Mostly clustered voltages, with ties, rail values and full-range noise
   function automatic logic [VOLT_W-1:0] pick_voltage(int base, int spread,
                                                      logic [VOLT_W-1:0] prev);
      int r, v;
      r = $urandom_range(99);
      if (r < 12) return prev;
      if (r < 15) return $urandom_range(1) ? {VOLT_W{1'b1}} : {VOLT_W{1'b0}};
      if (r < 20) return 16'($urandom);
      v = base + $urandom_range(spread);
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic send_scan(input int len, input logic charging);
      int                base, spread, mode;
      logic [VOLT_W-1:0] v;
      mode = $urandom_range(99);
      if (mode < 5) begin
         base   = 0;
         spread = 65535;
      end else if (mode < 15) begin
         // around and above the lowest-cell cap
         base   = 59990;
         spread = 5545;
      end else begin
         base   = phase_center - 20 + $urandom_range(20);
         spread = $urandom_range(5, 80);
      end
      v = base[15:0];
      for (int k = 0; k < len; k++) begin
         v = pick_voltage(base, spread, v);
         send_item(v, (k == len - 1) ? charging : 1'($urandom_range(1)), k == len - 1);
      end
   endtask

   initial begin
      cfg_type s;
      int      sent, len, r, n;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed scans at the reset register values
      for (int k = 0; k < CELL_SLOTS_DEF; k++)
         send_item(TIE_SCAN[k], 1'b1, k == CELL_SLOTS_DEF - 1);
      // charger idle, always-balance off: balancing off
      send_item(16'd0, 1'b0, 1'b1);
      // zero cell pulls the lowest reference down; rest of the pack is stale
      send_item(16'd0, 1'b1, 1'b1);
      // every cell above the lowest-cell cap
      for (int k = 0; k < CELL_SLOTS_DEF; k++)
         send_item(16'(60001 + $urandom_range(5534)), 1'b1, k == CELL_SLOTS_DEF - 1);
      wait_drained();

      // Random phases, each under its own register setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: s = '{4'd0, 16'($urandom_range(3000, 4300)), 16'd10, 1'b1, 4'd5};
            1: s = '{4'd15, 16'd0, 16'd0, 1'b1, 4'd15};
            2: s = '{4'd12, 16'hFFFF, 16'hFFFF, 1'b0, 4'd0};
            3: s = '{4'd13, 16'd4100, 16'd20, 1'b1, 4'd12};
            4: s = '{4'd1, 16'd4000, 16'd5, 1'b1, 4'd1};
            default: begin
               s.cell_count = ($urandom_range(9) == 0) ? 4'($urandom_range(13, 15))
                                                       : 4'($urandom_range(0, 12));
               s.balance_voltage = ($urandom_range(4) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(3000, 4300));
               s.diff_voltage = ($urandom_range(4) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 50));
               s.always_balance  = 1'($urandom_range(1));
               s.max_discharging = 4'($urandom_range(0, 15));
            end
         endcase
         apply_settings(s);

         phase_center = (s.balance_voltage >= 100 && s.balance_voltage <= 65000)
                        ? int'(s.balance_voltage) - 30 : $urandom_range(3000, 4300);
         idle_pct = (p == 3) ? 0 : 20;
         // long receiver hold while the sender keeps pushing
         if (p == 5) hold_request = 1'b1;
         n = (s.cell_count > CELL_SLOTS_DEF) ? CELL_SLOTS_DEF : s.cell_count;

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            r = $urandom_range(99);
            if (r < 60)      len = (n == 0) ? $urandom_range(1, CELL_SLOTS_DEF) : n;
            else if (r < 85) len = $urandom_range(1, CELL_SLOTS_DEF);
            else if (r < 93) len = $urandom_range(CELL_SLOTS_DEF + 1, CELL_SLOTS_DEF + 3);
            else             len = 1;
            send_scan(len, $urandom_range(99) < 70);
            sent += len;
            if ($urandom_range(29) == 0) wait_drained();
         end
         wait_drained();
      end

      idle_pct = 20;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.outstanding() != 0) begin
         $display("%0d results never arrived", tracker.outstanding());
         tracker.errors += tracker.outstanding();
      end
      if (tracker.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/cbs_pkg.sv
sv/cbs_csr.sv
sv/cbs_dp.sv
sv/cbs_ctrl.sv
sv/cell_balance_selector_core.sv
tb/tb_cell_balance_selector_core.sv
